### hw/rtl/bfgr_pkg.sv
package bfgr_pkg;

	// Font geometry limits
	localparam int MAX_WIDTH       = 32;
	localparam int MAX_GLYPH_BYTES = 128;
	localparam int GLYPH_COUNT     = 256;
	localparam int MEM_DEPTH       = GLYPH_COUNT * MAX_GLYPH_BYTES;
	localparam int ADDR_W          = $clog2(MEM_DEPTH);
	localparam int ROW_BYTES       = MAX_WIDTH / 8;
	localparam int BCNT_W          = $clog2(ROW_BYTES + 1);
	localparam int LANE_W          = $clog2(ROW_BYTES);
	localparam int COL_W           = $clog2(MAX_WIDTH);

	// Register widths and reset values
	localparam int CFG_DATA_W      = 8;
	localparam int CFG_INDEX_W     = 2;
	localparam logic [5:0] WIDTH_RST  = 6'd8;
	localparam logic [5:0] HEIGHT_RST = 6'd16;
	localparam logic [7:0] STRIDE_RST = 8'd16;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_GLYPH_WIDTH  = 2'd0,
		CFG_GLYPH_HEIGHT = 2'd1,
		CFG_GLYPH_STRIDE = 2'd2
	} cfg_idx_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_BASE,
		ST_READ,
		ST_EMIT
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic load;      // write the load byte into glyph memory
		logic capture;   // latch draw fields
		logic calc_base; // compute the row's first byte address
		logic rd_step;   // issue/collect row bytes
		logic emit;      // push one pixel into the output register
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic draw_ok;  // offered draw row produces pixels
		logic rd_done;  // all row bytes issued, last one landing now
		logic out_free; // output register can take a pixel
		logic last_col; // current column is the last of the row
	} sts_t;

endpackage

### hw/rtl/bfgr_ctrl.sv
module bfgr_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic          kind,
	input  bfgr_pkg::sts_t sts,
	output bfgr_pkg::cmd_t cmd
);
	import bfgr_pkg::*;

	state_t state_q;
	state_t state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (!kind) begin
						cmd.load = 1'b1;
					end else begin
						cmd.capture = 1'b1;
						if (sts.draw_ok) begin
							state_d = ST_BASE;
						end
					end
				end
			end
			ST_BASE: begin
				cmd.calc_base = 1'b1;
				state_d       = ST_READ;
			end
			ST_READ: begin
				cmd.rd_step = 1'b1;
				if (sts.rd_done) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					if (sts.last_col) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	a_busy_no_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !in_ready)
		else $error("input ready while a row is in progress");

	a_emit_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && sts.last_col) |=> (state_q == ST_IDLE))
		else $error("last pixel did not return to idle");

	a_read_after_base: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.calc_base |=> (state_q == ST_READ))
		else $error("base calculation not followed by row read");

endmodule

### hw/rtl/bfgr_dp.sv
module bfgr_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_write,
	input  logic [bfgr_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [bfgr_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic [14:0]                       load_address,
	input  logic [7:0]                        load_byte,
	input  logic [7:0]                        char_code,
	input  logic [4:0]                        glyph_row,
	input  logic [11:0]                       origin_x,
	input  logic [11:0]                       origin_y,
	input  logic [31:0]                       fg_color,
	input  logic [31:0]                       bg_color,
	input  bfgr_pkg::cmd_t                    cmd,
	output bfgr_pkg::sts_t                    sts,
	input  logic                              out_ready,
	output logic                              out_valid,
	output logic [12:0]                       pixel_x,
	output logic [12:0]                       pixel_y,
	output logic [31:0]                       pixel_color,
	output logic                              row_last
);
	import bfgr_pkg::*;

	logic [5:0]           width_q;
	logic [5:0]           height_q;
	logic [7:0]           stride_q;
	logic [5:0]           width_sat;
	logic [7:0]           stride_sat;
	logic [BCNT_W-1:0]    bpr;

	logic [7:0]           char_q;
	logic [4:0]           row_q;
	logic [11:0]          ox_q;
	logic [11:0]          oy_q;
	logic [31:0]          fg_q;
	logic [31:0]          bg_q;

	logic [ADDR_W-1:0]    base_q;
	logic [15:0]          glyph_off;
	logic [7:0]           row_off;
	logic [BCNT_W-1:0]    rd_cnt_q;
	logic                 rd_issue;
	logic [ADDR_W-1:0]    rd_addr;
	logic                 rd_vld_s1;
	logic [7:0]           rd_data_q;
	logic [LANE_W-1:0]    lane;
	logic [LANE_W-1:0]    byte_sel;
	logic [MAX_WIDTH-1:0] row_bits_q;
	logic [COL_W-1:0]     col_q;

	logic [7:0]           mem [MEM_DEPTH];

	logic                 out_valid_q;
	logic [12:0]          pixel_x_q;
	logic [12:0]          pixel_y_q;
	logic [31:0]          pixel_color_q;
	logic                 row_last_q;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RST;
			height_q <= HEIGHT_RST;
			stride_q <= STRIDE_RST;
		end else if (cfg_write) begin
			unique case (cfg_index)
				CFG_GLYPH_WIDTH:  width_q  <= cfg_data[5:0];
				CFG_GLYPH_HEIGHT: height_q <= cfg_data[5:0];
				CFG_GLYPH_STRIDE: stride_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Saturate geometry and derive bytes per row
	always_comb begin
		width_sat  = (width_q > 6'(MAX_WIDTH)) ? 6'(MAX_WIDTH) : width_q;
		stride_sat = (stride_q > 8'(MAX_GLYPH_BYTES)) ? 8'(MAX_GLYPH_BYTES) : stride_q;
		bpr        = BCNT_W'((7'(width_sat) + 7'd7) >> 3);
	end

	// Draw fields
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			char_q <= char_code;
			row_q  <= glyph_row;
			ox_q   <= origin_x;
			oy_q   <= origin_y;
			fg_q   <= fg_color;
			bg_q   <= bg_color;
		end
	end

	// Row start address, wrapping at the memory depth
	assign glyph_off = char_q * stride_sat;
	assign row_off   = 8'(row_q) * 8'(bpr);

	always_ff @(posedge clk) begin
		if (cmd.calc_base) begin
			base_q <= ADDR_W'(glyph_off + 16'(row_off));
		end
	end

	// Byte fetch counter
	assign rd_issue = cmd.rd_step && (rd_cnt_q < bpr);
	assign rd_addr  = base_q + ADDR_W'(rd_cnt_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_cnt_q  <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= rd_issue;
			if (cmd.calc_base) begin
				rd_cnt_q <= '0;
			end else if (rd_issue) begin
				rd_cnt_q <= rd_cnt_q + 1'b1;
			end
		end
	end

	// Glyph memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mem[load_address] <= load_byte;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_issue) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	// Place each fetched byte left-aligned, first byte at the top
	assign lane     = LANE_W'(rd_cnt_q - 1'b1);
	assign byte_sel = LANE_W'(ROW_BYTES - 1) - lane;

	always_ff @(posedge clk) begin
		if (rd_vld_s1) begin
			row_bits_q[8*byte_sel +: 8] <= rd_data_q;
		end else if (cmd.emit) begin
			row_bits_q <= row_bits_q << 1;
		end
	end

	// Column counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
		end else if (cmd.calc_base) begin
			col_q <= '0;
		end else if (cmd.emit) begin
			col_q <= col_q + 1'b1;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			pixel_x_q     <= 13'(ox_q) + 13'(col_q);
			pixel_y_q     <= 13'(oy_q) + 13'(row_q);
			pixel_color_q <= row_bits_q[MAX_WIDTH-1] ? fg_q : bg_q;
			row_last_q    <= sts.last_col;
		end
	end

	assign out_valid   = out_valid_q;
	assign pixel_x     = pixel_x_q;
	assign pixel_y     = pixel_y_q;
	assign pixel_color = pixel_color_q;
	assign row_last    = row_last_q;

	// Status back to the controller
	always_comb begin
		sts.draw_ok  = ({1'b0, glyph_row} < height_q) && (width_q != 6'd0);
		sts.rd_done  = cmd.rd_step && (rd_cnt_q == bpr);
		sts.out_free = !out_valid_q || out_ready;
		sts.last_col = ({1'b0, col_q} == (width_sat - 6'd1));
	end

	a_emit_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!out_valid_q || out_ready))
		else $error("pixel pushed over an untaken pixel");

	a_col_in_row: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> ({1'b0, col_q} < width_sat))
		else $error("column beyond glyph width");

	a_fetch_landed: assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_s1 |-> $past(cmd.rd_step))
		else $error("row byte landed without a fetch");

	a_done_last_byte: assert property (@(posedge clk) disable iff (!arst_n)
		sts.rd_done |-> rd_vld_s1)
		else $error("row fetch finished without its last byte");

endmodule

### hw/rtl/bitmap_font_glyph_row_renderer_top.sv
// Channel   Handshake              Carries
// in        in_valid / in_ready    kind, load_address, load_byte, char_code,
//                                  glyph_row, origin_x, origin_y, fg_color, bg_color
// out       out_valid / out_ready  pixel_x, pixel_y, pixel_color, row_last
// cfg       cfg_write              cfg_index, cfg_data (no wait, no read-back)
//
// A load beat, or a draw row outside the glyph height or of zero width, leaves
// the block idle. A drawn row steps through capture, base address, row fetch and
// pixel emit: the single glyph memory read port fetches one byte a cycle, then
// the output register takes one pixel a cycle while the output is not stalled.
// Reset clears the control state and loads the register defaults; glyph memory
// holds nothing valid until loaded. A stalled output holds the pixel sequence
// without loss; input is taken only between rows.
module bitmap_font_glyph_row_renderer_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_write,
	input  logic [bfgr_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [bfgr_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              kind,
	input  logic [14:0]                       load_address,
	input  logic [7:0]                        load_byte,
	input  logic [7:0]                        char_code,
	input  logic [4:0]                        glyph_row,
	input  logic [11:0]                       origin_x,
	input  logic [11:0]                       origin_y,
	input  logic [31:0]                       fg_color,
	input  logic [31:0]                       bg_color,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [12:0]                       pixel_x,
	output logic [12:0]                       pixel_y,
	output logic [31:0]                       pixel_color,
	output logic                              row_last
);
	import bfgr_pkg::*;

	cmd_t cmd;
	sts_t sts;

	bfgr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.kind     (kind),
		.sts      (sts),
		.cmd      (cmd)
	);

	bfgr_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.load_address (load_address),
		.load_byte    (load_byte),
		.char_code    (char_code),
		.glyph_row    (glyph_row),
		.origin_x     (origin_x),
		.origin_y     (origin_y),
		.fg_color     (fg_color),
		.bg_color     (bg_color),
		.cmd          (cmd),
		.sts          (sts),
		.out_ready    (out_ready),
		.out_valid    (out_valid),
		.pixel_x      (pixel_x),
		.pixel_y      (pixel_y),
		.pixel_color  (pixel_color),
		.row_last     (row_last)
	);

endmodule

### test/glyph_row_checker.sv
`timescale 1ns / 100ps

package glyph_tb_pkg;

	// Item kinds on the input channel
	localparam logic KIND_LOAD = 1'b0;
	localparam logic KIND_DRAW = 1'b1;

	typedef struct packed {
		logic [12:0] x;
		logic [12:0] y;
		logic [31:0] color;
		logic        last;
	} pixel_t;

endpackage

module glyph_row_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_write,
	input  logic [bfgr_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [bfgr_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                              in_valid,
	input  logic                              in_ready,
	input  logic                              kind,
	input  logic [14:0]                       load_address,
	input  logic [7:0]                        load_byte,
	input  logic [7:0]                        char_code,
	input  logic [4:0]                        glyph_row,
	input  logic [11:0]                       origin_x,
	input  logic [11:0]                       origin_y,
	input  logic [31:0]                       fg_color,
	input  logic [31:0]                       bg_color,
	input  logic                              out_valid,
	input  logic                              out_ready,
	input  logic [12:0]                       pixel_x,
	input  logic [12:0]                       pixel_y,
	input  logic [31:0]                       pixel_color,
	input  logic                              row_last,
	output int                                fail_count,
	output int                                pixels_pending
);

	import bfgr_pkg::*;
	import glyph_tb_pkg::*;

	// Shadow of the font store and the geometry registers
	logic [7:0] font_mem [MEM_DEPTH];
	logic [5:0] col_count;
	logic [5:0] row_count;
	logic [7:0] glyph_step;

	pixel_t pixels_due [$];

	task automatic note_mismatch(input string msg);
		fail_count++;
		$display("[%0t] mismatch: %s", $realtime, msg);
	endtask

	// Queue the pixels one draw beat should produce
	task automatic render_row(input logic [7:0] cc, input logic [4:0] gr,
			input logic [11:0] ox, input logic [11:0] oy,
			input logic [31:0] fg, input logic [31:0] bg);
		int unsigned w, s, bpr, base, addr, gx;
		pixel_t px;
		if (gr >= row_count)
			return;
		w = (col_count > MAX_WIDTH) ? MAX_WIDTH : col_count;
		s = (glyph_step > MAX_GLYPH_BYTES) ? MAX_GLYPH_BYTES : glyph_step;
		bpr = (w + 7) / 8;
		base = int'(cc) * s + int'(gr) * bpr;
		for (gx = 0; gx < w; gx++) begin
			addr = (base + gx / 8) % MEM_DEPTH;
			px.x = 13'(int'(ox) + gx);
			px.y = 13'(int'(oy) + int'(gr));
			px.color = font_mem[addr][7 - (gx % 8)] ? fg : bg;
			px.last = (gx + 1 == w);
			pixels_due.push_back(px);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_count = WIDTH_RST;
			row_count = HEIGHT_RST;
			glyph_step = STRIDE_RST;
			pixels_due.delete();
			fail_count = 0;
			pixels_pending <= 0;
		end else begin
			// Track register writes
			if (cfg_write) begin
				unique case (cfg_index)
					CFG_GLYPH_WIDTH:  col_count = cfg_data[5:0];
					CFG_GLYPH_HEIGHT: row_count = cfg_data[5:0];
					CFG_GLYPH_STRIDE: glyph_step = cfg_data[7:0];
					default: ;
				endcase
			end

			// Store a font byte or predict a row
			if (in_valid && in_ready) begin
				if (kind == KIND_LOAD)
					font_mem[load_address] = load_byte;
				else
					render_row(char_code, glyph_row, origin_x, origin_y, fg_color, bg_color);
			end

			// Compare each pixel beat with the oldest prediction
			if (out_valid && out_ready) begin
				if (pixels_due.size() == 0) begin
					note_mismatch($sformatf("pixel x=%0d y=%0d with nothing pending",
						pixel_x, pixel_y));
				end else begin
					pixel_t want;
					want = pixels_due.pop_front();
					if (pixel_x !== want.x)
						note_mismatch($sformatf("pixel_x got %0d want %0d", pixel_x, want.x));
					if (pixel_y !== want.y)
						note_mismatch($sformatf("pixel_y got %0d want %0d", pixel_y, want.y));
					if (pixel_color !== want.color)
						note_mismatch($sformatf("pixel_color got %h want %h at x=%0d y=%0d",
							pixel_color, want.color, want.x, want.y));
					if (row_last !== want.last)
						note_mismatch($sformatf("row_last got %b want %b at x=%0d y=%0d",
							row_last, want.last, want.x, want.y));
				end
			end

			pixels_pending <= pixels_due.size();
		end
	end

endmodule

### test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

	import bfgr_pkg::*;
	import glyph_tb_pkg::*;

	localparam int DRAIN_CYCLES = 64;
	localparam int LONG_HOLD    = 600;

	typedef enum int {RX_OPEN, RX_HALF, RX_MOSTLY, RX_SPARSE, RX_PATTERN} rx_mode_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_write = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic kind = 1'b0;
	logic [14:0] load_address = '0;
	logic [7:0] load_byte = '0;
	logic [7:0] char_code = '0;
	logic [4:0] glyph_row = '0;
	logic [11:0] origin_x = '0;
	logic [11:0] origin_y = '0;
	logic [31:0] fg_color = '0;
	logic [31:0] bg_color = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [12:0] pixel_x;
	logic [12:0] pixel_y;
	logic [31:0] pixel_color;
	logic row_last;

	int fail_count;
	int pixels_pending;

	// Stimulus-side view of the geometry and of which font bytes hold data
	logic [5:0] cur_w = WIDTH_RST;
	logic [5:0] cur_h = HEIGHT_RST;
	logic [7:0] cur_s = STRIDE_RST;
	bit font_written [MEM_DEPTH];

	bit idle_on = 1'b1;
	int burst_left = 0;
	int hold_asked = 0;
	int hold_done = 0;

	bitmap_font_glyph_row_renderer_top dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.kind(kind), .load_address(load_address), .load_byte(load_byte),
		.char_code(char_code), .glyph_row(glyph_row),
		.origin_x(origin_x), .origin_y(origin_y),
		.fg_color(fg_color), .bg_color(bg_color),
		.out_valid(out_valid), .out_ready(out_ready),
		.pixel_x(pixel_x), .pixel_y(pixel_y),
		.pixel_color(pixel_color), .row_last(row_last)
	);

	glyph_row_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.kind(kind), .load_address(load_address), .load_byte(load_byte),
		.char_code(char_code), .glyph_row(glyph_row),
		.origin_x(origin_x), .origin_y(origin_y),
		.fg_color(fg_color), .bg_color(bg_color),
		.out_valid(out_valid), .out_ready(out_ready),
		.pixel_x(pixel_x), .pixel_y(pixel_y),
		.pixel_color(pixel_color), .row_last(row_last),
		.fail_count(fail_count), .pixels_pending(pixels_pending)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Hard stop for a hung run
	initial begin
		#2_000_000;
		$display("FAIL");
		$finish;
	end

	function automatic logic [11:0] pick_coord();
		unique case ($urandom_range(0, 7))
			0: return 12'd0;
			1: return 12'hFFF;
			default: return 12'($urandom);
		endcase
	endfunction

	function automatic logic [31:0] pick_color();
		unique case ($urandom_range(0, 9))
			0: return 32'h0;
			1: return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [7:0] pick_code();
		unique case ($urandom_range(0, 7))
			0: return 8'd0;
			1: return 8'hFF;
			default: return 8'($urandom);
		endcase
	endfunction

	// Offer one beat; idle between bursts, hold until accepted
	task automatic offer(input logic k, input logic [14:0] la, input logic [7:0] lb,
			input logic [7:0] cc, input logic [4:0] gr,
			input logic [11:0] ox, input logic [11:0] oy,
			input logic [31:0] fg, input logic [31:0] bg);
		int gap;
		if (idle_on && burst_left == 0) begin
			gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 4);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
			burst_left = $urandom_range(1, 16);
		end
		in_valid <= 1'b1;
		kind <= k;
		load_address <= la;
		load_byte <= lb;
		char_code <= cc;
		glyph_row <= gr;
		origin_x <= ox;
		origin_y <= oy;
		fg_color <= fg;
		bg_color <= bg;
		do @(posedge clk); while (!in_ready);
		if (burst_left > 0)
			burst_left--;
	endtask

	task automatic put_font_byte(input logic [14:0] addr, input logic [7:0] value);
		offer(KIND_LOAD, addr, value, 8'($urandom), 5'($urandom), 12'($urandom),
			12'($urandom), $urandom, $urandom);
		font_written[addr] = 1'b1;
	endtask

	// Fill any row byte that was never loaded, then draw
	task automatic draw_row(input logic [7:0] cc, input logic [4:0] gr,
			input logic [11:0] ox, input logic [11:0] oy,
			input logic [31:0] fg, input logic [31:0] bg);
		int unsigned w, s, bpr, base, addr, k;
		if (gr < cur_h) begin
			w = (cur_w > MAX_WIDTH) ? MAX_WIDTH : cur_w;
			s = (cur_s > MAX_GLYPH_BYTES) ? MAX_GLYPH_BYTES : cur_s;
			bpr = (w + 7) / 8;
			base = int'(cc) * s + int'(gr) * bpr;
			for (k = 0; k < bpr; k++) begin
				addr = (base + k) % MEM_DEPTH;
				if (!font_written[addr])
					put_font_byte(15'(addr), 8'($urandom));
			end
		end
		offer(KIND_DRAW, 15'($urandom), 8'($urandom), cc, gr, ox, oy, fg, bg);
	endtask

	// Drain the block before touching the registers or ending
	task automatic settle();
		in_valid <= 1'b0;
		do @(posedge clk); while (pixels_pending != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic apply_config(input logic [5:0] w, input logic [5:0] h, input logic [7:0] s);
		settle();
		cfg_write <= 1'b1;
		cfg_index <= CFG_GLYPH_WIDTH;
		cfg_data <= {2'($urandom), w};
		@(posedge clk);
		cfg_index <= CFG_GLYPH_HEIGHT;
		cfg_data <= {2'($urandom), h};
		@(posedge clk);
		cfg_index <= CFG_GLYPH_STRIDE;
		cfg_data <= s;
		@(posedge clk);
		cfg_write <= 1'b0;
		cur_w = w;
		cur_h = h;
		cur_s = s;
	endtask

	task automatic random_item();
		int pick;
		int unsigned h_in;
		logic [4:0] gr;
		pick = $urandom_range(0, 99);
		h_in = (cur_h > 32) ? 32 : cur_h;
		if (pick < 12) begin
			put_font_byte(15'($urandom), 8'($urandom));
		end else begin
			// Mostly rows inside the glyph, some past its height
			if (pick < 20)
				gr = (h_in < 32) ? 5'($urandom_range(h_in, 31)) : 5'($urandom);
			else if (h_in == 0)
				gr = 5'($urandom);
			else
				gr = 5'($urandom_range(0, h_in - 1));
			draw_row(pick_code(), gr, pick_coord(), pick_coord(), pick_color(), pick_color());
		end
	endtask

	task automatic run_random(input int count);
		repeat (count) random_item();
	endtask

	// Receiver: segments of different stall patterns, plus one long hold on request
	initial begin
		int seg_left;
		rx_mode_t mode;
		seg_left = 0;
		mode = RX_OPEN;
		forever begin
			@(posedge clk);
			if (hold_asked != hold_done) begin
				out_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				hold_done = hold_asked;
			end else begin
				if (seg_left == 0) begin
					mode = rx_mode_t'($urandom_range(0, 4));
					seg_left = $urandom_range(20, 200);
				end
				seg_left--;
				unique case (mode)
					RX_OPEN:   out_ready <= 1'b1;
					RX_HALF:   out_ready <= 1'($urandom_range(0, 1));
					RX_MOSTLY: out_ready <= ($urandom_range(0, 3) != 0);
					RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
					default:   out_ready <= ((seg_left % 7) < 4);
				endcase
			end
		end
	end

	// Stimulus and verdict
	initial begin
		int i;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed rows at the reset geometry: 8 wide, 16 high, stride 16
		put_font_byte(15'd0, 8'h80);
		draw_row(8'd0, 5'd0, 12'd0, 12'd0, 32'h0, 32'hFFFF_FFFF);
		put_font_byte(15'd4095, 8'h01);
		draw_row(8'hFF, 5'd15, 12'hFFF, 12'hFFF, 32'hFFFF_FFFF, 32'h0);
		put_font_byte(15'h7FFF, 8'hFF);
		put_font_byte(15'h4000, 8'hA5);
		draw_row(8'd10, 5'd16, 12'd5, 12'd5, 32'h1234_5678, 32'h9ABC_DEF0);
		draw_row(8'd200, 5'd31, 12'd7, 12'd9, 32'h1, 32'h2);
		put_font_byte(15'(8'h41 * 16 + 3), 8'h55);
		draw_row(8'h41, 5'd3, 12'd100, 12'd200, 32'hAAAA_AAAA, 32'h5555_5555);
		put_font_byte(15'(8'h41 * 16 + 4), 8'hAA);
		draw_row(8'h41, 5'd4, 12'd100, 12'd201, 32'hAAAA_AAAA, 32'h5555_5555);
		put_font_byte(15'd16, 8'hFF);
		draw_row(8'd1, 5'd0, 12'hFF8, 12'd0, 32'hDEAD_BEEF, 32'h0BAD_F00D);
		put_font_byte(15'd33, 8'h00);
		draw_row(8'd2, 5'd1, 12'd0, 12'hFFE, 32'hDEAD_BEEF, 32'h0BAD_F00D);
		draw_row(8'd0, 5'd0, 12'd1, 12'd1, 32'hCAFE_0001, 32'hCAFE_0001);

		// Geometry extremes and corner settings
		apply_config(6'd1, 6'd1, 8'd1);
		run_random(20);
		apply_config(6'd32, 6'd32, 8'd128);
		run_random(20);
		apply_config(6'd0, 6'd16, 8'd16);      // zero width: rows produce nothing
		run_random(10);
		apply_config(6'd12, 6'd0, 8'd3);       // zero height: every row out of range
		run_random(10);
		apply_config(6'd63, 6'd63, 8'd255);    // width and stride saturate
		run_random(12);
		apply_config(6'd13, 6'd20, 8'd0);      // zero stride: all glyphs share the bytes from address 0
		idle_on = 1'b0;
		run_random(20);
		idle_on = 1'b1;

		// Back-pressure: receiver holds off while the sender keeps offering
		apply_config(6'd32, 6'd8, 8'd64);
		idle_on = 1'b0;
		hold_asked++;
		run_random(15);
		idle_on = 1'b1;

		// Random geometries
		for (i = 0; i < 6; i++) begin
			apply_config(($urandom_range(0, 5) == 0) ? 6'($urandom_range(33, 63))
					: 6'($urandom_range(1, 32)),
				6'($urandom_range(1, 40)),
				($urandom_range(0, 2) == 0) ? 8'($urandom) : 8'($urandom_range(1, 40)));
			run_random(10);
		end

		settle();
		if (fail_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
